FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define DTTN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dttn assertion failed");

// Check that a condition implies another in the next cycle.
`define DTTN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dttn assertion failed");

`endif

FILE: rtl/dttn_pkg.sv
`default_nettype none

package dttn_pkg;

    // Fraction digits kept in real mode (0 to 6)
    localparam int MAX_FRAC_DIGITS = 6;
    localparam int FRAC_DIGITS_CAP = 6;

    // Field and datapath widths
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 20;
    localparam int FDIG_W  = 3;
    localparam int QUO_W   = 17;
    localparam int CNT_W   = 5;
    localparam int MAG_W   = 34;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Token kinds
    localparam logic KIND_INT  = 1'b0;
    localparam logic KIND_REAL = 1'b1;

    // Range limits
    localparam logic [ACC_W-1:0] INT_POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] INT_NEG_LIMIT  = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] WHOLE_LIMIT    = 64'd32768;
    localparam logic [MAG_W-1:0] REAL_POS_LIMIT = 34'h0_7FFF_FFFF;
    localparam logic [MAG_W-1:0] REAL_NEG_LIMIT = 34'h0_8000_0000;

    // Controller states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic take;
        logic div_load;
        logic div_step;
        logic load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_dp_status;

    // Scale for a count of kept fraction digits
    function automatic logic [FRAC_W-1:0] pow_ten(input logic [FDIG_W-1:0] idx);
        logic [FRAC_W-1:0] p;
        case (idx)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            default: p = 20'd1000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dttn_if.sv
`default_nettype none

// Input byte channel
interface dttn_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_byte;
    logic       first;
    logic       last;

    modport source (output valid, output kind, output char_byte, output first,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_byte, input first,
                    input last, output ready);
endinterface

// Result channel
interface dttn_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [63:0] number;

    modport source (output valid, output ok, output number, input ready);
    modport sink   (input valid, input ok, input number, output ready);
endinterface

`default_nettype wire

FILE: rtl/decimal_token_to_number.sv
// One byte per cycle is accepted, except while input is stalled as described below.
// An integer token's last byte goes to the finish state, which loads the result; a real token's
// last byte first passes the prepare state and the 17-step bit-serial fraction divider.
// Input stalls only from a last byte until its result enters the output register.
// Reset (synchronous, active low) clears the token state, controller and output valid.
`default_nettype none

`include "assert_macros.svh"

module decimal_token_to_number
    import dttn_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dttn_in_if.sink       i_in,
    dttn_out_if.source    o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       out_valid;
    logic       res_ok;
    logic signed [63:0] res_number;

    // Sequence byte intake, division and result loading
    dttn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .i_in_last   (i_in.last),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Accumulate digits, divide and convert
    dttn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_in.kind),
        .i_char_byte (i_in.char_byte),
        .i_first     (i_in.first),
        .o_status    (status),
        .o_ok        (res_ok),
        .o_number    (res_number)
    );

    assign i_in.ready   = in_ready;
    assign o_out.valid  = out_valid;
    assign o_out.ok     = res_ok;
    assign o_out.number = res_number;

    // A last byte stalls intake until its result is stored
    `DTTN_ASSERT_NXT(a_last_stalls, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.last, !i_in.ready)
    // A failed conversion carries a zero number
    `DTTN_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_out.valid && !o_out.ok, o_out.number == 64'sd0)
    // A result loads only into a free output register
    `DTTN_ASSERT_IMP(a_load_free, i_clk, i_rst_n, cmd.load, !o_out.valid || o_out.ready)

endmodule

`default_nettype wire

FILE: rtl/dttn_ctrl.sv
`default_nettype none

module dttn_ctrl
    import dttn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_kind,
    input  logic       i_in_last,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   take;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = i_in_valid && (r_state == ST_RUN);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (take && i_in_last) begin
                    n_state = (i_in_kind == KIND_REAL) ? ST_PREP : ST_FIN;
                end
            end
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.take     = 1'b0;
        o_cmd.div_load = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.load     = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_in_ready = 1'b1;
                o_cmd.take = take;
            end
            ST_PREP: o_cmd.div_load = 1'b1;
            ST_DIV:  o_cmd.div_step = !i_status.div_done;
            ST_FIN:  o_cmd.load     = out_free;
            default: o_in_ready     = 1'b0;
        endcase
    end

    // Hold the result until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/dttn_dp.sv
`default_nettype none

module dttn_dp
    import dttn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_kind,
    input  logic [7:0]         i_char_byte,
    input  logic               i_first,
    output t_dp_status         o_status,
    output logic               o_ok,
    output logic signed [63:0] o_number
);

    // Token state
    logic              r_neg, n_neg;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [FDIG_W-1:0] r_fdig, n_fdig;
    logic              r_point, n_point;
    logic              r_digit, n_digit;
    logic              r_bad, n_bad;
    logic              r_kind;

    // Divider
    logic [FRAC_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [FRAC_W-1:0] r_scale;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // Result register
    logic               r_ok;
    logic signed [63:0] r_number;

    // Byte step working values
    logic              b_neg;
    logic [ACC_W-1:0]  b_acc;
    logic [FRAC_W-1:0] b_frac;
    logic [FDIG_W-1:0] b_fdig;
    logic              b_point, b_digit, b_bad;
    logic [3:0]        dig;
    logic [ACC_W+3:0]  prod;
    logic [ACC_W+3:0]  int_limit;
    logic [FRAC_W+3:0] frac_prod;
    logic              is_sign, is_digit;

    assign is_sign  = (i_char_byte == CH_PLUS) || (i_char_byte == CH_MINUS);
    assign is_digit = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_NINE);
    assign dig      = 4'(i_char_byte - CH_ZERO);

    // Start from cleared state on the first byte
    always_comb begin
        b_neg   = i_first ? 1'b0 : r_neg;
        b_acc   = i_first ? '0 : r_acc;
        b_frac  = i_first ? '0 : r_frac;
        b_fdig  = i_first ? '0 : r_fdig;
        b_point = i_first ? 1'b0 : r_point;
        b_digit = i_first ? 1'b0 : r_digit;
        b_bad   = i_first ? 1'b0 : r_bad;
    end

    assign prod      = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1) + {{ACC_W{1'b0}}, dig};
    assign int_limit = {4'b0, (b_neg ? INT_NEG_LIMIT : INT_POS_LIMIT)};
    assign frac_prod = ({4'b0, b_frac} << 3) + ({4'b0, b_frac} << 1)
                     + {{FRAC_W{1'b0}}, dig};

    // Apply one byte to the token state
    always_comb begin
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        n_point = r_point;
        n_digit = r_digit;
        n_bad   = r_bad;
        if (i_cmd.take) begin
            n_neg   = b_neg;
            n_acc   = b_acc;
            n_frac  = b_frac;
            n_fdig  = b_fdig;
            n_point = b_point;
            n_digit = b_digit;
            n_bad   = b_bad;
            if (!b_bad) begin
                if (i_first && is_sign) begin
                    n_neg = (i_char_byte == CH_MINUS);
                end else if (i_kind == KIND_REAL && i_char_byte == CH_POINT && !b_point) begin
                    n_point = 1'b1;
                end else if (!is_digit) begin
                    n_bad = 1'b1;
                end else begin
                    n_digit = 1'b1;
                    if (i_kind == KIND_INT) begin
                        if (prod > int_limit) begin
                            n_bad = 1'b1;
                        end else begin
                            n_acc = prod[ACC_W-1:0];
                        end
                    end else if (!b_point) begin
                        if (b_acc > WHOLE_LIMIT) begin
                            n_bad = 1'b1;
                        end else begin
                            n_acc = prod[ACC_W-1:0];
                        end
                    end else if (b_fdig < FDIG_W'(MAX_FRAC_DIGITS)
                                 && b_fdig < FDIG_W'(FRAC_DIGITS_CAP)) begin
                        n_frac = frac_prod[FRAC_W-1:0];
                        n_fdig = b_fdig + FDIG_W'(1);
                    end
                end
            end
        end else if (i_cmd.load) begin
            // Drop the token once its result is stored
            n_neg   = 1'b0;
            n_acc   = '0;
            n_frac  = '0;
            n_fdig  = '0;
            n_point = 1'b0;
            n_digit = 1'b0;
            n_bad   = 1'b0;
        end
    end

    // Restoring divider for the rounded fraction
    logic [FRAC_W-1:0] ld_scale;
    logic [36:0]       ld_num;
    logic [FRAC_W:0]   trial;
    logic [FRAC_W:0]   trial_sub;

    assign ld_scale  = pow_ten(r_fdig);
    assign ld_num    = {1'b0, r_frac, 16'b0} + {17'b0, 1'b0, ld_scale[FRAC_W-1:1]};
    assign trial     = {r_rem, r_quo[QUO_W-1]};
    assign trial_sub = trial - {1'b0, r_scale};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (i_cmd.div_load) begin
            n_rem = ld_num[36:QUO_W];
            n_quo = ld_num[QUO_W-1:0];
            n_cnt = CNT_W'(QUO_W);
        end else if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_scale}) begin
                n_rem = trial_sub[FRAC_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = trial[FRAC_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    assign o_status.div_done = (r_cnt == '0);

    // Final conversion
    logic               f_ok;
    logic signed [63:0] f_number;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   real_limit;

    assign mag        = {r_acc[17:0], 16'b0} + {{(MAG_W-QUO_W){1'b0}}, r_quo};
    assign real_limit = r_neg ? REAL_NEG_LIMIT : REAL_POS_LIMIT;

    always_comb begin
        f_ok     = !r_bad && r_digit;
        f_number = '0;
        if (r_kind == KIND_INT) begin
            f_number = r_neg ? -$signed(r_acc) : $signed(r_acc);
        end else begin
            if (r_acc > WHOLE_LIMIT || mag > real_limit) begin
                f_ok = 1'b0;
            end
            f_number = $signed({30'b0, mag});
            if (r_neg) begin
                f_number = -f_number;
            end
        end
        if (!f_ok) begin
            f_number = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_frac  <= '0;
            r_fdig  <= '0;
            r_point <= 1'b0;
            r_digit <= 1'b0;
            r_bad   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_fdig  <= n_fdig;
            r_point <= n_point;
            r_digit <= n_digit;
            r_bad   <= n_bad;
            r_cnt   <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_cmd.take) begin
            r_kind <= i_kind;
        end
        if (i_cmd.div_load) begin
            r_scale <= ld_scale;
        end
        if (i_cmd.load) begin
            r_ok     <= f_ok;
            r_number <= f_number;
        end
    end

    assign o_ok     = r_ok;
    assign o_number = r_number;

endmodule

`default_nettype wire
